// File: sv/tbpc_pkg.sv
// Shared types, register indexes, reset values and result codes of the button press classifier.
package tbpc_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CODE_WIDTH          = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_POLL_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_POLLS      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHORT_LIMIT    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MEDIUM_LIMIT   = 3'd4;

   // Register values after reset.
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] POLL_TICKS_RESET     = 16'd10;
   localparam logic [CFG_WIDTH-1:0] MAX_POLLS_RESET      = 16'd300;
   localparam logic [CFG_WIDTH-1:0] SHORT_LIMIT_RESET    = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] MEDIUM_LIMIT_RESET   = 16'd3000;

   // Codes of the which_buttons field.
   localparam logic [CODE_WIDTH-1:0] WHICH_RED  = 2'd0;
   localparam logic [CODE_WIDTH-1:0] WHICH_BLUE = 2'd1;
   localparam logic [CODE_WIDTH-1:0] WHICH_BOTH = 2'd2;

   // Codes of the press_class field.
   localparam logic [CODE_WIDTH-1:0] CLASS_SHORT  = 2'd0;
   localparam logic [CODE_WIDTH-1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [CODE_WIDTH-1:0] CLASS_LONG   = 2'd2;

   // Flag bits: bit 0 is red, bit 1 is blue.
   localparam logic [1:0] FLAGS_RED  = 2'b01;
   localparam logic [1:0] FLAGS_BOTH = 2'b11;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] poll_ticks;
      logic [CFG_WIDTH-1:0] max_polls;
      logic [CFG_WIDTH-1:0] short_limit;
      logic [CFG_WIDTH-1:0] medium_limit;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic red_level;
      logic blue_level;
   } tick_type;

endpackage

// File: sv/tbpc_csr.sv
// Configuration registers of the button press classifier.
module tbpc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tbpc_pkg::CFG_WIDTH-1:0]       csr_data,
   output tbpc_pkg::cfg_type                    cfg
);

   tbpc_pkg::cfg_type cfg_ff;
   tbpc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tbpc_pkg::REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_data;
            tbpc_pkg::REG_POLL_TICKS:     cfg_in.poll_ticks     = csr_data;
            tbpc_pkg::REG_MAX_POLLS:      cfg_in.max_polls      = csr_data;
            tbpc_pkg::REG_SHORT_LIMIT:    cfg_in.short_limit    = csr_data;
            tbpc_pkg::REG_MEDIUM_LIMIT:   cfg_in.medium_limit   = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= tbpc_pkg::DEBOUNCE_TICKS_RESET;
         cfg_ff.poll_ticks     <= tbpc_pkg::POLL_TICKS_RESET;
         cfg_ff.max_polls      <= tbpc_pkg::MAX_POLLS_RESET;
         cfg_ff.short_limit    <= tbpc_pkg::SHORT_LIMIT_RESET;
         cfg_ff.medium_limit   <= tbpc_pkg::MEDIUM_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/tbpc_in_reg.sv
// Input register that holds one tick beat until the core takes it.
module tbpc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_red_level,
   input  logic               req_blue_level,
   input  logic               take,
   output tbpc_pkg::tick_type tick
);

   logic valid_ff;
   logic valid_in;
   logic red_ff;
   logic blue_ff;

   assign req_ready       = !valid_ff || take;
   assign valid_in        = req_ready ? req_valid : valid_ff;
   assign tick.valid      = valid_ff;
   assign tick.red_level  = red_ff;
   assign tick.blue_level = blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         red_ff  <= req_red_level;
         blue_ff <= req_blue_level;
      end
   end

endmodule

// File: sv/tbpc_core.sv
// Edge latching, debounce and poll sequencing, classification and the result register.
module tbpc_core #(
   parameter int TIMER_WIDTH = tbpc_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tbpc_pkg::cfg_type                    cfg,
   input  tbpc_pkg::tick_type                   tick,
   output logic                                 take,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tbpc_pkg::CODE_WIDTH-1:0]      rsp_which_buttons,
   output logic [tbpc_pkg::CODE_WIDTH-1:0]      rsp_press_class,
   output logic [tbpc_pkg::CFG_WIDTH-1:0]       rsp_press_ticks
);

   localparam int CW       = tbpc_pkg::CFG_WIDTH;
   localparam int CMP_W    = (TIMER_WIDTH > CW) ? TIMER_WIDTH : CW;
   localparam int PROD_W   = TIMER_WIDTH + CW;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_POLL     = 2'd2
   } phase_type;

   localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

   phase_type              phase_ff,  phase_in;
   logic                   last_red_ff, last_red_in;
   logic                   last_blue_ff, last_blue_in;
   logic [1:0]             pend_ff,   pend_in;
   logic [1:0]             snap_ff,   snap_in;
   logic [TIMER_WIDTH-1:0] tick_ff,   tick_in;
   logic [TIMER_WIDTH-1:0] poll_ff,   poll_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [tbpc_pkg::CODE_WIDTH-1:0] which_ff, which_in;
   logic [tbpc_pkg::CODE_WIDTH-1:0] class_ff, class_in;
   logic [CW-1:0]          ticks_ff,  ticks_in;

   logic [1:0]             pend_new;
   logic [CW-1:0]          interval;
   logic [TIMER_WIDTH-1:0] tick_inc;
   logic [TIMER_WIDTH-1:0] poll_inc;
   logic [PROD_W-1:0]      prod;
   logic [CW-1:0]          press_time;
   logic                   held;
   logic                   emit;

   // A counter at its maximum has reached any limit.
   function automatic logic reached(input logic [TIMER_WIDTH-1:0] count,
                                    input logic [CW-1:0] limit);
      logic [CMP_W-1:0] c;
      logic [CMP_W-1:0] l;
      c = CMP_W'(count);
      l = CMP_W'(limit);
      return (c >= l) || (count == CNT_MAX);
   endfunction

   assign take = tick.valid && (!rsp_valid_ff || rsp_ready);

   assign pend_new = pend_ff | {last_blue_ff & ~tick.blue_level,
                                last_red_ff & ~tick.red_level};
   assign interval = (cfg.poll_ticks == '0) ? CW'(1) : cfg.poll_ticks;
   assign tick_inc = (tick_ff == CNT_MAX) ? CNT_MAX : tick_ff + 1'b1;
   assign poll_inc = (poll_ff == CNT_MAX) ? CNT_MAX : poll_ff + 1'b1;
   assign prod     = PROD_W'(poll_inc) * PROD_W'(interval);
   assign press_time = (prod[PROD_W-1:CW] != '0) ? {CW{1'b1}} : prod[CW-1:0];

   always_comb begin
      case (snap_ff)
         tbpc_pkg::FLAGS_BOTH: held = !tick.red_level && !tick.blue_level;
         tbpc_pkg::FLAGS_RED:  held = !tick.red_level;
         default:              held = !tick.blue_level;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      last_red_in  = last_red_ff;
      last_blue_in = last_blue_ff;
      pend_in      = pend_ff;
      snap_in      = snap_ff;
      tick_in      = tick_ff;
      poll_in      = poll_ff;
      emit         = 1'b0;
      which_in     = which_ff;
      class_in     = class_ff;
      ticks_in     = ticks_ff;
      if (take) begin
         last_red_in  = tick.red_level;
         last_blue_in = tick.blue_level;
         pend_in      = pend_new;
         case (phase_ff)
            PH_DEBOUNCE: begin
               tick_in = tick_inc;
               if (reached(tick_inc, cfg.debounce_ticks)) begin
                  snap_in  = pend_new;
                  phase_in = PH_POLL;
                  tick_in  = '0;
                  poll_in  = '0;
               end
            end
            PH_POLL: begin
               tick_in = tick_inc;
               if (reached(tick_inc, interval)) begin
                  tick_in = '0;
                  poll_in = poll_inc;
                  if (!held || reached(poll_inc, cfg.max_polls)) begin
                     emit     = 1'b1;
                     ticks_in = press_time;
                     case (snap_ff)
                        tbpc_pkg::FLAGS_BOTH: which_in = tbpc_pkg::WHICH_BOTH;
                        tbpc_pkg::FLAGS_RED:  which_in = tbpc_pkg::WHICH_RED;
                        default:              which_in = tbpc_pkg::WHICH_BLUE;
                     endcase
                     if (press_time < cfg.short_limit) begin
                        class_in = tbpc_pkg::CLASS_SHORT;
                     end else if (press_time < cfg.medium_limit) begin
                        class_in = tbpc_pkg::CLASS_MEDIUM;
                     end else begin
                        class_in = tbpc_pkg::CLASS_LONG;
                     end
                     pend_in  = pend_new & ~snap_ff;
                     snap_in  = '0;
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                     poll_in  = '0;
                  end
               end
            end
            default: begin
               // The unused phase code is handled like idle.
               phase_in = PH_IDLE;
               if (pend_new != '0) begin
                  phase_in = PH_DEBOUNCE;
                  tick_in  = '0;
               end
            end
         endcase
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         last_red_ff  <= 1'b1;
         last_blue_ff <= 1'b1;
         pend_ff      <= '0;
         snap_ff      <= '0;
         tick_ff      <= '0;
         poll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         last_red_ff  <= last_red_in;
         last_blue_ff <= last_blue_in;
         pend_ff      <= pend_in;
         snap_ff      <= snap_in;
         tick_ff      <= tick_in;
         poll_ff      <= poll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      which_ff <= which_in;
      class_ff <= class_in;
      ticks_ff <= ticks_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_which_buttons = which_ff;
   assign rsp_press_class   = class_ff;
   assign rsp_press_ticks   = ticks_ff;

endmodule

// File: sv/two_button_press_classifier_unit.sv
// Top level of the two-button press classifier.
// Data path: a tick beat is taken into the input register, and the result it causes is
// then written to the result register when the core takes the beat from the input register.
// Throughput: one tick beat per cycle; the core takes a beat whenever the result register
// is empty or being drained, so only a stalled result channel slows the input.
// Reset: synchronous and active high; registers return to their defaults, buttons read
// released, no edges pending, phase idle and counters at zero.
module two_button_press_classifier_unit #(
   parameter int TIMER_WIDTH = tbpc_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_red_level,
   input  logic                                 req_blue_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tbpc_pkg::CODE_WIDTH-1:0]      rsp_which_buttons,
   output logic [tbpc_pkg::CODE_WIDTH-1:0]      rsp_press_class,
   output logic [tbpc_pkg::CFG_WIDTH-1:0]       rsp_press_ticks,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tbpc_pkg::CFG_WIDTH-1:0]       csr_data
);

   tbpc_pkg::cfg_type  cfg;
   tbpc_pkg::tick_type tick;
   logic               take;

   tbpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tbpc_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red_level  (req_red_level),
      .req_blue_level (req_blue_level),
      .take           (take),
      .tick           (tick)
   );

   tbpc_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .tick              (tick),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_which_buttons (rsp_which_buttons),
      .rsp_press_class   (rsp_press_class),
      .rsp_press_ticks   (rsp_press_ticks)
   );

endmodule
